>>> hdl/ptlfk_pkg.sv
// Shared constants, types and the quarter-wave sine table for the two-link arm kinematics.
// No dependencies; every other file imports this package.
package ptlfk_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int ANGLE_W     = 9;
    localparam int LEN_W       = 10;
    localparam int POINT_W     = 21;
    localparam int TRIG_W      = 31;
    localparam int IDX_W       = 7;
    localparam int Q_BITS      = 30;
    localparam int PROD_W      = LEN_W + TRIG_W;
    localparam int ROUND_SHIFT = Q_BITS - FRAC_BITS;
    localparam int TERM_W      = PROD_W - ROUND_SHIFT;
    localparam int ACC_W       = (FRAC_BITS + 13 > POINT_W) ? FRAC_BITS + 13 : POINT_W;
    localparam int CELL_LAT    = 4;
    localparam int LINK_COUNT  = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int SINE_DEPTH  = 91;

    localparam logic [31:0] DEG_Q30 = 32'd18740330;
    localparam logic [ANGLE_W:0] FULL_TURN    = (ANGLE_W + 1)'(360);
    localparam logic [ANGLE_W:0] QUARTER_TURN = (ANGLE_W + 1)'(90);
    localparam logic [PROD_W-1:0] ROUND_BIAS  = PROD_W'(1) << (ROUND_SHIFT - 1);

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [TRIG_W-1:0] sine_table_t [0:SINE_DEPTH-1];

    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } trig_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_OFFSET        = 2'd0,
        CFG_FIRST_LINK_LENGTH  = 2'd1,
        CFG_SECOND_LINK_LENGTH = 2'd2
    } cfg_reg_t;

    // Taylor series to the x^15 term, each term truncated to Q30.
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        int          d;
        int          k;
        for (d = 0; d < SINE_DEPTH; d++) begin
            if (d == 0) begin
                tbl[d] = '0;
            end
            else if (d == SINE_DEPTH - 1) begin
                tbl[d] = TRIG_W'(1) << Q_BITS;
            end
            else begin
                x    = 64'(d) * 64'(DEG_Q30);
                x2   = (x * x) >> Q_BITS;
                term = x;
                sum  = x;
                for (k = 1; k <= 7; k++) begin
                    term = (term * x2) >> Q_BITS;
                    term = term / 64'((2 * k) * (2 * k + 1));
                    if ((k % 2) == 1) begin
                        sum = sum - term;
                    end
                    else begin
                        sum = sum + term;
                    end
                end
                tbl[d] = sum[TRIG_W-1:0];
            end
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

    // Operand below twice a full turn.
    function automatic logic [ANGLE_W-1:0] wrap_angle(input logic [ANGLE_W:0] a);
        logic [ANGLE_W:0] w;
        w = (a >= FULL_TURN) ? a - FULL_TURN : a;
        return w[ANGLE_W-1:0];
    endfunction

endpackage

>>> hdl/ptlfk_ifs.sv
// Valid/ready channel interfaces for joint angle input and end point output.
// Depends on ptlfk_pkg.
interface ptlfk_in_if
    import ptlfk_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_first;
    logic [ANGLE_W-1:0] angle_second;

    modport source (output valid, output angle_first, output angle_second, input ready);
    modport sink (input valid, input angle_first, input angle_second, output ready);
endinterface

interface ptlfk_out_if
    import ptlfk_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink (input valid, input point_x, input point_y, output ready);
endinterface

>>> hdl/ptlfk_link_cell.sv
// One link of the arm: adds its joint angle, looks up sine/cosine, scales by the link length
// and accumulates into x/y. Four register stages. Depends on ptlfk_pkg.
module ptlfk_link_cell
    import ptlfk_pkg::*;
(
    input  logic               clk,
    input  logic               advance,
    input  logic [LEN_W-1:0]   link_length,
    input  logic [ANGLE_W-1:0] angle_in,
    input  logic [ANGLE_W-1:0] delta,
    input  acc_t               x_in,
    input  acc_t               y_in,
    output logic [ANGLE_W-1:0] angle_out,
    output acc_t               x_out,
    output acc_t               y_out
);

    function automatic trig_t trig_lookup(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0] r;
        logic [1:0]         quad;
        logic [IDX_W-1:0]   idx;
        trig_t              t;
        if (a < ANGLE_W'(90)) begin
            quad = 2'd0;
            r    = a;
        end
        else if (a < ANGLE_W'(180)) begin
            quad = 2'd1;
            r    = a - ANGLE_W'(90);
        end
        else if (a < ANGLE_W'(270)) begin
            quad = 2'd2;
            r    = a - ANGLE_W'(180);
        end
        else begin
            quad = 2'd3;
            r    = a - ANGLE_W'(270);
        end
        idx   = quad[0] ? IDX_W'(QUARTER_TURN) - IDX_W'(r) : IDX_W'(r);
        t.neg = quad[1];
        t.mag = SINE_TABLE[idx];
        return t;
    endfunction

    // Round half away from zero, then apply sign.
    function automatic acc_t scale_term(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W-1:0] biased;
        logic [TERM_W-1:0] q;
        acc_t              ext;
        biased = p + ROUND_BIAS;
        q      = biased[PROD_W-1:ROUND_SHIFT];
        ext    = {{(ACC_W - TERM_W){1'b0}}, q};
        return neg ? -ext : ext;
    endfunction

    logic [ANGLE_W-1:0] angle_sum;
    logic [ANGLE_W-1:0] angle_cos;

    logic [ANGLE_W-1:0] s0_angle_reg;
    logic [ANGLE_W-1:0] s0_cos_angle_reg;
    acc_t               s0_x_reg;
    acc_t               s0_y_reg;

    logic [ANGLE_W-1:0] s1_angle_reg;
    trig_t              s1_sin_reg;
    trig_t              s1_cos_reg;
    acc_t               s1_x_reg;
    acc_t               s1_y_reg;

    logic [ANGLE_W-1:0] s2_angle_reg;
    logic [PROD_W-1:0]  s2_sin_prod_reg;
    logic [PROD_W-1:0]  s2_cos_prod_reg;
    logic               s2_sin_neg_reg;
    logic               s2_cos_neg_reg;
    acc_t               s2_x_reg;
    acc_t               s2_y_reg;

    logic [ANGLE_W-1:0] s3_angle_reg;
    acc_t               s3_x_reg;
    acc_t               s3_y_reg;

    assign angle_sum = wrap_angle({1'b0, angle_in} + {1'b0, delta});
    assign angle_cos = wrap_angle({1'b0, angle_sum} + QUARTER_TURN);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_angle_reg     <= angle_sum;
            s0_cos_angle_reg <= angle_cos;
            s0_x_reg         <= x_in;
            s0_y_reg         <= y_in;

            s1_angle_reg <= s0_angle_reg;
            s1_sin_reg   <= trig_lookup(s0_angle_reg);
            s1_cos_reg   <= trig_lookup(s0_cos_angle_reg);
            s1_x_reg     <= s0_x_reg;
            s1_y_reg     <= s0_y_reg;

            s2_angle_reg    <= s1_angle_reg;
            s2_sin_prod_reg <= link_length * s1_sin_reg.mag;
            s2_cos_prod_reg <= link_length * s1_cos_reg.mag;
            s2_sin_neg_reg  <= s1_sin_reg.neg;
            s2_cos_neg_reg  <= s1_cos_reg.neg;
            s2_x_reg        <= s1_x_reg;
            s2_y_reg        <= s1_y_reg;

            s3_angle_reg <= s2_angle_reg;
            s3_x_reg     <= s2_x_reg + scale_term(s2_cos_prod_reg, s2_cos_neg_reg);
            s3_y_reg     <= s2_y_reg + scale_term(s2_sin_prod_reg, s2_sin_neg_reg);
        end
    end

    assign angle_out = s3_angle_reg;
    assign x_out     = s3_x_reg;
    assign y_out     = s3_y_reg;

endmodule

>>> hdl/planar_two_link_forward_kinematics.sv
// Two-link planar arm forward kinematics, top level.
// Depends on ptlfk_pkg, ptlfk_ifs and ptlfk_link_cell.
//
// Usage:
//   in_chan  : valid/ready, one transaction carries angle_first and angle_second in degrees
//              (values of 360 and above are taken modulo 360).
//   out_chan : valid/ready, one transaction carries point_x and point_y, signed, with
//              FRAC_BITS fraction bits, saturated to 21 bits.
//   cfg_*    : write port for base_offset, first_link_length, second_link_length;
//              write only while no transaction is in flight.
// Path: two link cells of four stages each, then the output register; the first stage
// loads on the accepting edge.
// Throughput: one transaction per cycle while out_chan is not stalled; the pipeline of link cells moves as a whole.
// Stall: while out_chan holds a result that is not taken, every stage holds and
// in_chan.ready is low; it rises again in the cycle the result is taken.
// Reset: the pipeline empties and the registers return to 10, 20 and 10.
module planar_two_link_forward_kinematics
    import ptlfk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ptlfk_in_if.sink             in_chan,
    ptlfk_out_if.source          out_chan,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEN_W-1:0]     cfg_data
);

    localparam int PIPE_STAGES = LINK_COUNT * CELL_LAT;

    function automatic logic signed [POINT_W-1:0] saturate(input acc_t v);
        if (v > acc_t'(2 ** (POINT_W - 1) - 1)) begin
            return {1'b0, {(POINT_W - 1){1'b1}}};
        end
        else if (v < acc_t'(-(2 ** (POINT_W - 1)))) begin
            return {1'b1, {(POINT_W - 1){1'b0}}};
        end
        return v[POINT_W-1:0];
    endfunction

    logic [LEN_W-1:0] base_offset_reg;
    logic [LEN_W-1:0] first_link_length_reg;
    logic [LEN_W-1:0] second_link_length_reg;

    logic                      advance;
    logic [PIPE_STAGES-1:0]    stage_valid_reg;
    logic [PIPE_STAGES-1:0]    stage_valid_next;
    logic                      out_valid_reg;
    logic signed [POINT_W-1:0] point_x_reg;
    logic signed [POINT_W-1:0] point_y_reg;
    logic [ANGLE_W-1:0]        second_dly_reg [0:CELL_LAT-1];

    logic [ANGLE_W-1:0] first_wrapped;
    logic [ANGLE_W-1:0] second_wrapped;
    acc_t               base_x;
    logic [ANGLE_W-1:0] mid_angle;
    acc_t               mid_x;
    acc_t               mid_y;
    logic [ANGLE_W-1:0] end_angle;
    acc_t               end_x;
    acc_t               end_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_offset_reg        <= LEN_W'(10);
            first_link_length_reg  <= LEN_W'(20);
            second_link_length_reg <= LEN_W'(10);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_BASE_OFFSET:        base_offset_reg        <= cfg_data;
                CFG_FIRST_LINK_LENGTH:  first_link_length_reg  <= cfg_data;
                CFG_SECOND_LINK_LENGTH: second_link_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance       = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = advance;

    assign first_wrapped  = wrap_angle({1'b0, in_chan.angle_first});
    assign second_wrapped = wrap_angle({1'b0, in_chan.angle_second});
    assign base_x = {{(ACC_W - LEN_W - FRAC_BITS){1'b0}}, base_offset_reg, {FRAC_BITS{1'b0}}};

    assign stage_valid_next = {stage_valid_reg[PIPE_STAGES-2:0], in_chan.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= stage_valid_reg[PIPE_STAGES-1];
        end
    end

    // Second joint angle waits for the first cell.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            second_dly_reg[0] <= second_wrapped;
            for (int i = 1; i < CELL_LAT; i++)
            begin
                second_dly_reg[i] <= second_dly_reg[i-1];
            end
            point_x_reg <= saturate(end_x);
            point_y_reg <= saturate(end_y);
        end
    end

    ptlfk_link_cell u_first_cell (
        .clk         (clk),
        .advance     (advance),
        .link_length (first_link_length_reg),
        .angle_in    ('0),
        .delta       (first_wrapped),
        .x_in        (base_x),
        .y_in        ('0),
        .angle_out   (mid_angle),
        .x_out       (mid_x),
        .y_out       (mid_y)
    );

    ptlfk_link_cell u_second_cell (
        .clk         (clk),
        .advance     (advance),
        .link_length (second_link_length_reg),
        .angle_in    (mid_angle),
        .delta       (second_dly_reg[CELL_LAT-1]),
        .x_in        (mid_x),
        .y_in        (mid_y),
        .angle_out   (end_angle),
        .x_out       (end_x),
        .y_out       (end_y)
    );

    assign out_chan.valid   = out_valid_reg;
    assign out_chan.point_x = point_x_reg;
    assign out_chan.point_y = point_y_reg;

    a_end_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[PIPE_STAGES-1] |-> (end_angle < ANGLE_W'(360)))
        else $error("accumulated joint angle out of range");

    a_mid_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg[CELL_LAT-1] |-> (mid_angle < ANGLE_W'(360)))
        else $error("first joint angle out of range");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stage_valid_reg) && $stable(out_valid_reg))
        else $error("pipeline moved during stall");

endmodule
